@@ design/fpsqrt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fpsqrt_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK  = 3'd0,
        ST_NAN = 3'd1,
        ST_NEG = 3'd2,
        ST_INF = 3'd3,
        ST_OVF = 3'd4
    } status_t;

endpackage

`default_nettype wire

@@ design/fixed_point_square_root_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Fixed-point square root, signed raw values with FRAC_BITS fraction bits.
// s_tdata carries one raw operand per item; m_tdata returns the truncated
// root floor(sqrt(v * 2^FRAC_BITS)) and m_tuser its status code (fpsqrt_pkg::status_t).
// Most negative code is NaN, most positive code is infinity (passed through),
// other negative operands give the most negative code, a root beyond the
// most positive code saturates and reports overflow.
// Pipeline: each item passes through ROOT_W root stages, where
// ROOT_W = ceil((DATA_WIDTH - 1 + FRAC_BITS) / 2), one pipeline stage per
// root bit plus the input and output registers.
// Throughput: one item per cycle unless m_tready stalls the output; the
// restoring-digit pipeline has no state carried between items.
// Reset clears all valid bits; no item is pending afterwards.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
module fixed_point_square_root_unit #(
    parameter int DATA_WIDTH = fpsqrt_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = fpsqrt_pkg::FRAC_BITS_DEF,
    localparam int TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output      logic               s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // [DATA_WIDTH-1:0] raw_value
    output      logic               m_tvalid,
    input  wire logic               m_tready,
    output      logic [TDATA_W-1:0] m_tdata,   // [DATA_WIDTH-1:0] root_value
    output      logic [7:0]         m_tuser    // [2:0] status
);

    localparam int RAD_W  = DATA_WIDTH - 1 + FRAC_BITS;
    localparam int RAD_W2 = RAD_W + (RAD_W % 2);
    localparam int ROOT_W = RAD_W2 / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int EXT_W  = (ROOT_W > DATA_WIDTH) ? ROOT_W : DATA_WIDTH;

    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic advance;

    // stage 0 is the input register, stage k holds k root bits
    logic                valid_reg [0:ROOT_W];
    fpsqrt_pkg::status_t spec_reg  [0:ROOT_W];
    logic [RAD_W2-1:0]   rad_reg   [0:ROOT_W];
    logic [REM_W-1:0]    rem_reg   [0:ROOT_W];
    logic [ROOT_W-1:0]   q_reg     [0:ROOT_W];

    logic                 m_tvalid_reg;
    logic [DATA_WIDTH-1:0] root_reg;
    fpsqrt_pkg::status_t  status_reg;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    // ---- input classification ----
    logic [DATA_WIDTH-1:0] raw;
    logic [DATA_WIDTH-2:0] mag;
    fpsqrt_pkg::status_t   spec_next;
    logic [RAD_W2-1:0]     rad_next;

    always_comb begin
        raw = s_tdata[DATA_WIDTH-1:0];
        mag = raw[DATA_WIDTH-2:0];
        priority if (raw[DATA_WIDTH-1] && mag == '0) begin
            spec_next = fpsqrt_pkg::ST_NAN;
        end else if (raw[DATA_WIDTH-1]) begin
            spec_next = fpsqrt_pkg::ST_NEG;
        end else if (&mag) begin
            spec_next = fpsqrt_pkg::ST_INF;
        end else begin
            spec_next = fpsqrt_pkg::ST_OK;
        end
        // special codes run through with a zero radicand
        if (spec_next == fpsqrt_pkg::ST_OK) begin
            rad_next = RAD_W2'(mag) << FRAC_BITS;
        end else begin
            rad_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (advance) begin
            valid_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            spec_reg[0] <= spec_next;
            rad_reg[0]  <= rad_next;
            rem_reg[0]  <= '0;
            q_reg[0]    <= '0;
        end
    end

    // ---- one root bit per stage, restoring digit recurrence ----
    for (genvar k = 1; k <= ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  cur;
        logic [REM_W-1:0]  trial;
        logic              ge;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] q_next;

        always_comb begin
            cur      = {rem_reg[k-1][REM_W-3:0], rad_reg[k-1][RAD_W2-1 -: 2]};
            trial    = {q_reg[k-1], 2'b01};
            ge       = (cur >= trial);
            rem_next = ge ? (cur - trial) : cur;
            q_next   = {q_reg[k-1][ROOT_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (advance) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                spec_reg[k] <= spec_reg[k-1];
                rad_reg[k]  <= rad_reg[k-1] << 2;
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
            end
        end
    end

    // ---- saturation and output register ----
    logic [EXT_W-1:0]      q_ext;
    logic                  ovf;
    logic [DATA_WIDTH-1:0] root_next;
    fpsqrt_pkg::status_t   status_next;

    always_comb begin
        q_ext       = EXT_W'(q_reg[ROOT_W]);
        ovf         = (q_ext > EXT_W'(MAX_POS));
        root_next   = q_ext[DATA_WIDTH-1:0];
        status_next = spec_reg[ROOT_W];
        unique case (spec_reg[ROOT_W])
            fpsqrt_pkg::ST_NAN, fpsqrt_pkg::ST_NEG: begin
                root_next = MIN_NEG;
            end
            fpsqrt_pkg::ST_INF: begin
                root_next = MAX_POS;
            end
            default: begin
                if (ovf) begin
                    root_next   = MAX_POS;
                    status_next = fpsqrt_pkg::ST_OVF;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= valid_reg[ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            root_reg   <= root_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(root_reg);
    assign m_tuser  = 8'(status_reg);

endmodule

`default_nettype wire
